// ----- rtl/core/hbc_pkg.sv -----
// shared types and constants for the histogram bin counter
// no dependencies
package hbc_pkg;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_BELOW = 2'd1;
   localparam logic [1:0] OP_TOP   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_NOCFG  = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   localparam logic [1:0] REG_LOW   = 2'd0;
   localparam logic [1:0] REG_HIGH  = 2'd1;
   localparam logic [1:0] REG_WIDTH = 2'd2;
   localparam logic [1:0] REG_CLAMP = 2'd3;

   localparam int unsigned CSR_ADDR_W = 2;

   // classified word from the front to the back
   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  status;
      logic [16:0] idx;
   } cmd_type;

endpackage

// ----- rtl/core/histogram_bin_counter.sv -----
// histogram bin counter, top level
// depends on hbc_pkg, hbc_front, hbc_queue, hbc_back
//
// usage:
//  - csr channel writes range_low (0), range_high (1), bucket_width (2) and
//    clamp_out_of_range (3); write only while idle. each write is followed by
//    a recompute of the bucket count, during which requests stall.
//  - req channel takes an op and a Q16.16 value; rsp returns one word per item.
//  - an add sample inside the range runs a 33-step bit-serial divider in the
//    front and a read-modify-write in the back.
//    out-of-range, clear and top queries skip the divider.
//  - count-below and highest-bucket queries walk the count memory one bucket
//    a cycle, up to the bucket index or the active bucket count.
//  - clear sweeps all MAX_BUCKETS entries, one a cycle.
//  - a two-entry queue lets the front classify the next word while the back
//    works or waits on rsp_stall; a stalled response holds.
//  - after reset the back clears the count memory before the first response
//    is produced.
module histogram_bin_counter #(
   parameter int unsigned MAX_BUCKETS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hbc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_op,
   input  logic signed [31:0]             req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status,
   output logic [7:0]                     rsp_bucket,
   output logic [31:0]                    rsp_count_value,
   output logic [31:0]                    rsp_total_samples
);
   import hbc_pkg::*;

   localparam int unsigned IDX_W = 17;
   localparam int unsigned ADDR_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

   logic             f_valid, q_full, q_valid, q_pop;
   cmd_type          f_cmd, q_cmd;
   logic [IDX_W-1:0] act;

   hbc_front #(.MAX_BUCKETS(MAX_BUCKETS), .IDX_W(IDX_W)) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .req_valid(req_valid), .req_stall(req_stall),
      .req_op(req_op), .req_value(req_value),
      .cmd_valid(f_valid), .cmd_full(q_full), .cmd(f_cmd), .active_out(act)
   );

   hbc_queue u_queue (
      .clock(clock), .reset(reset), .push(f_valid), .push_cmd(f_cmd), .full(q_full),
      .pop_valid(q_valid), .pop(q_pop), .pop_cmd(q_cmd)
   );

   hbc_back #(.MAX_BUCKETS(MAX_BUCKETS), .IDX_W(IDX_W), .ADDR_W(ADDR_W)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(q_valid), .cmd_pop(q_pop), .cmd(q_cmd),
      .active_buckets(act), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_bucket(rsp_bucket),
      .rsp_count_value(rsp_count_value), .rsp_total_samples(rsp_total_samples)
   );
endmodule

// ----- rtl/core/hbc_divider.sv -----
// restoring divider, one quotient bit a cycle, round half even
// no dependencies
module hbc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] num,
   input  logic [30:0] den,
   output logic        busy,
   output logic        done,
   output logic [33:0] quot
);
   logic [32:0] q_ff, q_in;
   logic [31:0] r_ff, r_in;
   logic [30:0] d_ff, d_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] twice_r;
   logic        up;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[32]} - {2'b0, d_ff};
      if (start) begin
         q_in = num; r_in = '0; d_in = den; cnt_in = 6'd33; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            r_in = trial[31:0];
            q_in = {q_ff[31:0], 1'b1};
         end else begin
            r_in = {r_ff[30:0], q_ff[32]};
            q_in = {q_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign twice_r = {r_ff, 1'b0};
   assign up = (twice_r > {2'b0, d_ff}) || ((twice_r == {2'b0, d_ff}) && q_ff[0]);
   assign quot = {1'b0, q_ff} + {33'b0, up};
   assign busy = busy_ff;
   assign done = done_ff;
endmodule

// ----- rtl/core/hbc_front.sv -----
// front end: config registers, bucket count derivation and value classification
// depends on hbc_pkg and hbc_divider
module hbc_front #(
   parameter int unsigned MAX_BUCKETS = 256,
   parameter int unsigned IDX_W = 17
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hbc_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [31:0]                    csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_op,
   input  logic signed [31:0]             req_value,
   output logic                           cmd_valid,
   input  logic                           cmd_full,
   output hbc_pkg::cmd_type               cmd,
   output logic [IDX_W-1:0]               active_out
);
   import hbc_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0, S_DERIVE = 2'd1, S_MAP = 2'd2, S_PUSH = 2'd3;
   localparam logic [33:0] MAXB = 34'(MAX_BUCKETS);

   logic signed [31:0] low_ff, low_in, high_ff, high_in;
   logic [30:0] width_ff, width_in;
   logic        clamp_ff, clamp_in;
   logic [IDX_W-1:0] act_ff, act_in;
   logic [1:0]  st_ff, st_in;
   cmd_type     cmd_ff, cmd_in;
   logic        cfg_ok, div_start, div_busy, div_done;
   logic [32:0] div_num;
   logic [33:0] quot, nq;

   assign cfg_ok = (width_ff != '0) && (low_ff < high_ff);

   hbc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(width_ff),
      .busy(div_busy), .done(div_done), .quot(quot)
   );

   assign csr_ready = (st_ff == S_IDLE);
   assign req_stall = (st_ff != S_IDLE) || csr_valid;

   always_comb begin
      low_in = low_ff; high_in = high_ff; width_in = width_ff; clamp_in = clamp_ff;
      act_in = act_ff; st_in = st_ff; cmd_in = cmd_ff;
      div_start = 1'b0;
      div_num = 33'({high_ff[31], high_ff} - {low_ff[31], low_ff});
      nq = quot + 34'd1;
      case (st_ff)
         S_IDLE: begin
            if (csr_valid && csr_ready) begin
               case (csr_index)
                  REG_LOW:   low_in = csr_data;
                  REG_HIGH:  high_in = csr_data;
                  REG_WIDTH: width_in = csr_data[30:0];
                  REG_CLAMP: clamp_in = csr_data[0];
                  default: ;
               endcase
               st_in = S_DERIVE;
            end else if (req_valid && !req_stall) begin
               cmd_in.op = req_op; cmd_in.status = ST_OK; cmd_in.idx = '0;
               if (req_op == OP_CLEAR) begin
                  st_in = S_PUSH;
               end else if (!cfg_ok || act_ff == '0) begin
                  cmd_in.status = ST_NOCFG; st_in = S_PUSH;
               end else if (req_op == OP_TOP) begin
                  st_in = S_PUSH;
               end else if (req_value < low_ff) begin
                  if (clamp_ff) cmd_in.idx = '0;
                  else cmd_in.status = ST_REJECT;
                  st_in = S_PUSH;
               end else if (req_value > high_ff) begin
                  if (clamp_ff) cmd_in.idx = 17'(act_ff - 1'b1);
                  else cmd_in.status = ST_REJECT;
                  st_in = S_PUSH;
               end else begin
                  div_num = 33'({req_value[31], req_value} - {low_ff[31], low_ff});
                  div_start = 1'b1; st_in = S_MAP;
               end
            end
         end
         S_DERIVE: begin
            // first cycle starts the divide, done ends it
            if (!cfg_ok) begin
               act_in = '0; st_in = S_IDLE;
            end else if (!div_busy && !div_done) begin
               div_start = 1'b1;
            end else if (div_done) begin
               act_in = (nq > MAXB) ? IDX_W'(MAX_BUCKETS) : IDX_W'(nq);
               st_in = S_IDLE;
            end
         end
         S_MAP: begin
            if (div_done) begin
               if (quot >= 34'(act_ff)) begin
                  if (clamp_ff) cmd_in.idx = 17'(act_ff - 1'b1);
                  else cmd_in.status = ST_REJECT;
               end else begin
                  cmd_in.idx = 17'(quot);
               end
               st_in = S_PUSH;
            end
         end
         S_PUSH: if (!cmd_full) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (reset) begin
         low_ff <= '0; high_ff <= '0; width_ff <= '0; clamp_ff <= 1'b0;
         act_ff <= '0; st_ff <= S_IDLE;
      end else begin
         low_ff <= low_in; high_ff <= high_in; width_ff <= width_in; clamp_ff <= clamp_in;
         act_ff <= act_in; st_ff <= st_in;
      end
   end

   assign cmd_valid = (st_ff == S_PUSH);
   assign cmd = cmd_ff;
   assign active_out = act_ff;

   a_push_only_push: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> (st_ff == S_PUSH)) else $error("push outside push state");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_MAP) |-> req_stall) else $error("request taken while mapping");
   a_act_cap: assert property (@(posedge clock) disable iff (reset)
      act_ff <= IDX_W'(MAX_BUCKETS)) else $error("bucket count over cap");
endmodule

// ----- rtl/core/hbc_queue.sv -----
// two-entry command queue between front and back
// depends on hbc_pkg
module hbc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hbc_pkg::cmd_type push_cmd,
   output logic             full,
   output logic             pop_valid,
   input  logic             pop,
   output hbc_pkg::cmd_type pop_cmd
);
   import hbc_pkg::*;
   cmd_type mem_ff [2];
   logic    wp_ff, rp_ff;
   logic [1:0] n_ff;

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wp_ff] <= push_cmd;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; n_ff <= '0;
      end else begin
         if (push && !full) wp_ff <= !wp_ff;
         if (pop && pop_valid) rp_ff <= !rp_ff;
         n_ff <= n_ff + 2'((push && !full)) - 2'((pop && pop_valid));
      end
   end
   assign full = (n_ff == 2'd2);
   assign pop_valid = (n_ff != 2'd0);
   assign pop_cmd = mem_ff[rp_ff];

   a_cnt: assert property (@(posedge clock) disable iff (reset) n_ff <= 2'd2)
      else $error("queue count overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (n_ff == 2'd0 || n_ff == 2'd2) |-> (wp_ff == rp_ff)) else $error("pointer skew");
   a_ptr1: assert property (@(posedge clock) disable iff (reset)
      (n_ff == 2'd1) |-> (wp_ff != rp_ff)) else $error("pointer skew one");
endmodule

// ----- rtl/core/hbc_back.sv -----
// back end: count memory, clearing sweep, bucket walks and result register
// depends on hbc_pkg
module hbc_back #(
   parameter int unsigned MAX_BUCKETS = 256,
   parameter int unsigned IDX_W = 17,
   parameter int unsigned ADDR_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  hbc_pkg::cmd_type  cmd,
   input  logic [IDX_W-1:0]  active_buckets,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_bucket,
   output logic [31:0]       rsp_count_value,
   output logic [31:0]       rsp_total_samples
);
   import hbc_pkg::*;

   localparam logic [2:0] B_INIT = 3'd0, B_IDLE = 3'd1, B_RD = 3'd2, B_WR = 3'd3,
                          B_WALK = 3'd4, B_CLR = 3'd5, B_OUT = 3'd6;

   logic [31:0] mem [MAX_BUCKETS];
   logic [31:0] rd_ff;
   logic [2:0]  st_ff, st_in;
   logic [IDX_W-1:0] i_ff, i_in, lim_ff, lim_in, hit_ff, hit_in;
   logic        found_ff, found_in;
   cmd_type     c_ff, c_in;
   logic [31:0] tot_ff, tot_in, sum_ff, sum_in;
   logic [1:0]  o_st_ff, o_st_in;
   logic [7:0]  o_bk_ff, o_bk_in;
   logic [31:0] o_cv_ff, o_cv_in;
   logic        we, rdp_in, rdp_ff;
   logic [ADDR_W-1:0] wa, ra;
   logic [31:0] wd;
   logic [32:0] add;

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[ra];
   end

   always_comb begin
      st_in = st_ff; i_in = i_ff; lim_in = lim_ff; hit_in = hit_ff; found_in = found_ff;
      c_in = c_ff; tot_in = tot_ff; sum_in = sum_ff;
      o_st_in = o_st_ff; o_bk_in = o_bk_ff; o_cv_in = o_cv_ff;
      we = 1'b0; wa = i_ff[ADDR_W-1:0]; wd = '0; ra = i_ff[ADDR_W-1:0];
      cmd_pop = 1'b0; rdp_in = 1'b0;
      add = {1'b0, sum_ff} + {1'b0, rd_ff};
      case (st_ff)
         B_INIT, B_CLR: begin
            we = 1'b1;
            i_in = i_ff + 1'b1;
            if (i_ff == IDX_W'(MAX_BUCKETS - 1)) st_in = (st_ff == B_INIT) ? B_IDLE : B_OUT;
         end
         B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1; c_in = cmd;
               o_st_in = cmd.status; o_bk_in = '0; o_cv_in = '0;
               i_in = '0; sum_in = '0; found_in = 1'b0;
               if (cmd.op == OP_CLEAR) begin
                  tot_in = '0; st_in = B_CLR;
               end else if (cmd.status != ST_OK) begin
                  st_in = B_OUT;
               end else if (cmd.op == OP_ADD) begin
                  i_in = IDX_W'(cmd.idx); st_in = B_RD;
               end else if (cmd.op == OP_BELOW) begin
                  lim_in = IDX_W'(cmd.idx); o_bk_in = cmd.idx[7:0];
                  st_in = (cmd.idx == '0) ? B_OUT : B_WALK;
               end else begin
                  lim_in = active_buckets; st_in = B_WALK;
               end
            end
         end
         B_RD: st_in = B_WR;
         B_WR: begin
            we = 1'b1;
            wd = (rd_ff == '1) ? rd_ff : rd_ff + 32'd1;
            if (tot_ff != '1) tot_in = tot_ff + 32'd1;
            o_bk_in = i_ff[7:0];
            st_in = B_OUT;
         end
         B_WALK: begin
            // address issued while i_ff < lim, data checked in the following cycle
            if (rdp_ff) begin
               if (c_ff.op == OP_BELOW) sum_in = add[32] ? '1 : add[31:0];
               else if (rd_ff != '0) begin
                  found_in = 1'b1; hit_in = i_ff - 1'b1;
               end
            end
            if (i_ff < lim_ff) begin
               rdp_in = 1'b1; i_in = i_ff + 1'b1;
            end else if (!rdp_ff) begin
               if (c_ff.op == OP_BELOW) o_cv_in = sum_in;
               else if (found_in) o_bk_in = hit_in[7:0];
               else o_st_in = ST_EMPTY;
               st_in = B_OUT;
            end
         end
         B_OUT: if (!rsp_stall) st_in = B_IDLE;
         default: st_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in; sum_ff <= sum_in; lim_ff <= lim_in; hit_ff <= hit_in;
      found_ff <= found_in; o_st_ff <= o_st_in; o_bk_ff <= o_bk_in; o_cv_ff <= o_cv_in;
      if (reset) begin
         st_ff <= B_INIT; i_ff <= '0; tot_ff <= '0; rdp_ff <= 1'b0;
      end else begin
         st_ff <= st_in; i_ff <= i_in; tot_ff <= tot_in; rdp_ff <= rdp_in;
      end
   end

   assign rsp_valid = (st_ff == B_OUT);
   assign rsp_status = o_st_ff;
   assign rsp_bucket = o_bk_ff;
   assign rsp_count_value = o_cv_ff;
   assign rsp_total_samples = tot_ff;

   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (st_ff == B_IDLE)) else $error("pop outside idle");
   a_walk_lim: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_WALK) |-> (i_ff <= lim_ff)) else $error("walk overran limit");
   a_clr_tot: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_CLR) |-> (tot_ff == '0)) else $error("total not cleared");
endmodule
